// ----- sv/assert_macros.svh -----
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  `ASSERT_PROP(lbl, clk, rstn, !(expr))

`endif

// ----- sv/pdw_pkg.sv -----
`timescale 1ns / 1ps
package pdw_pkg;

  localparam int DEF_IMAGE_WIDTH  = 640;
  localparam int DEF_IMAGE_HEIGHT = 480;

  // divider pipeline: quotient bits per stage and stage count
  localparam int DBITS = 4;
  localparam int NDIV  = 32 / DBITS;

  typedef logic signed [33:0] q30_t;

  localparam q30_t Q30_ONE     = 34'sd1073741824;
  localparam q30_t Q30_HALF_PI = 34'sd1686629713;
  localparam q30_t Q30_PI      = 34'sd3373259426;
  localparam logic [32:0] CAM_LIMIT = 33'h0_FFFF_FFFF;

  // register indexes
  localparam logic [2:0] REG_ROLL  = 3'd0;
  localparam logic [2:0] REG_PITCH = 3'd1;
  localparam logic [2:0] REG_YAW   = 3'd2;
  localparam logic [2:0] REG_POS_X = 3'd3;
  localparam logic [2:0] REG_POS_Y = 3'd4;
  localparam logic [2:0] REG_POS_Z = 3'd5;
  localparam logic [2:0] REG_FOCAL = 3'd6;

  typedef struct packed {
    logic [16:0] rx;
    logic [31:0] qx;
    logic [16:0] ry;
    logic [31:0] qy;
    logic        ox;
    logic        oy;
    logic        sx;
    logic        sy;
    logic [23:0] dep;
  } div_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rot_stat_t;

  // q30 product, rounded half up
  function automatic logic signed [37:0] mul30(input q30_t a, input q30_t b);
    logic signed [67:0] pr;
    pr = a * b + 68'sd536870912;
    return pr[67:30];
  endfunction

  // DBITS restoring division steps on both projection lanes
  function automatic div_t div_stage(input div_t d, input logic [16:0] dv);
    div_t        o;
    logic [17:0] r2;
    logic        ge;
    o = d;
    for (int i = 0; i < DBITS; i++) begin
      r2 = {o.rx, o.qx[31]};
      ge = (r2 >= {1'b0, dv});
      o.rx = ge ? 17'(r2 - {1'b0, dv}) : r2[16:0];
      o.qx = {o.qx[30:0], ge};
      r2 = {o.ry, o.qy[31]};
      ge = (r2 >= {1'b0, dv});
      o.ry = ge ? 17'(r2 - {1'b0, dv}) : r2[16:0];
      o.qy = {o.qy[30:0], ge};
    end
    return o;
  endfunction

endpackage

// ----- sv/pdw_rot.sv -----
`timescale 1ns / 1ps
module pdw_rot (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [15:0]       yaw,
  input  logic [15:0]       pitch,
  input  logic [15:0]       roll,
  output pdw_pkg::rot_stat_t stat,
  output pdw_pkg::q30_t     mat [9]
);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_X2   = 3'd1;
  localparam logic [2:0] ST_HMUL = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SMUL = 3'd4;
  localparam logic [2:0] ST_MAT  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam logic [1:0] MD_SET = 2'd0;
  localparam logic [1:0] MD_ADD = 2'd1;
  localparam logic [1:0] MD_SUB = 2'd2;

  localparam logic [3:0] DST_TMP  = 4'd9;
  localparam logic [3:0] OP_LAST  = 4'd13;
  localparam logic [2:0] H_LAST   = 3'd4;
  localparam logic [1:0] K_LAST   = 2'd2;

  logic [2:0]    st_r;
  logic [1:0]    k_r;
  logic [2:0]    h_r;
  logic          cph_r;
  logic [3:0]    op_r;
  pdw_pkg::q30_t t_r, x2_r, p_r, tmp_r;
  logic          neg_r, dneg_r;
  logic [31:0]   dabs_r;
  pdw_pkg::q30_t sn_r [3];
  pdw_pkg::q30_t cs_r [3];
  pdw_pkg::q30_t mat_r [9];

  logic [15:0]   ang;
  pdw_pkg::q30_t t_ext, t_fold;
  logic          t_neg;
  pdw_pkg::q30_t ma, mb, m, opa, opb;
  logic [3:0]    odst;
  logic [1:0]    omd;
  logic [33:0]   mabs;
  logic [32:0]   rm;
  logic [5:0]    rsh;
  logic [64:0]   qprod;
  logic [31:0]   qmag;
  pdw_pkg::q30_t qs, pn;
  logic [37:0]   mw;

  // horner divisors as reciprocals ceil(2^s / d), sine then cosine;
  // exact truncation for dividends below 2^32
  function automatic logic [32:0] hrecip(input logic cph, input logic [2:0] h);
    case ({cph, h})
      4'b0000: return 33'd4997780127; // 110
      4'b0001: return 33'd7635497416; // 72
      4'b0010: return 33'd6544712071; // 42
      4'b0011: return 33'd6871947674; // 20
      4'b0100: return 33'd5726623062; // 6
      4'b1000: return 33'd6108397933; // 90
      4'b1001: return 33'd4908534053; // 56
      4'b1010: return 33'd4581298450; // 30
      4'b1011: return 33'd5726623062; // 12
      4'b1100: return 33'd4294967296; // 2
      default: return 33'd4294967296;
    endcase
  endfunction

  function automatic logic [5:0] hshift(input logic cph, input logic [2:0] h);
    case ({cph, h})
      4'b0000: return 6'd39;
      4'b0001: return 6'd39;
      4'b0010: return 6'd38;
      4'b0011: return 6'd37;
      4'b0100: return 6'd35;
      4'b1000: return 6'd39;
      4'b1001: return 6'd38;
      4'b1010: return 6'd37;
      4'b1011: return 6'd36;
      4'b1100: return 6'd33;
      default: return 6'd32;
    endcase
  endfunction

  always_comb begin
    case (k_r)
      2'd0:    ang = yaw;
      2'd1:    ang = pitch;
      default: ang = roll;
    endcase
    t_ext = {ang[15], ang, 17'd0};
    t_neg = 1'b1;
    if (t_ext > pdw_pkg::Q30_HALF_PI) begin
      t_fold = t_ext - pdw_pkg::Q30_PI;
    end else if (t_ext < -pdw_pkg::Q30_HALF_PI) begin
      t_fold = t_ext + pdw_pkg::Q30_PI;
    end else begin
      t_fold = t_ext;
      t_neg  = 1'b0;
    end
  end

  // matrix schedule: sa=sn[0] sb=sn[1] sg=sn[2], likewise for cosines
  always_comb begin
    opa  = cs_r[0];
    opb  = sn_r[1];
    odst = DST_TMP;
    omd  = MD_SET;
    case (op_r)
      4'd0:  begin opa = cs_r[0]; opb = sn_r[1]; odst = DST_TMP; omd = MD_SET; end
      4'd1:  begin opa = tmp_r;   opb = sn_r[2]; odst = 4'd1;    omd = MD_SET; end
      4'd2:  begin opa = sn_r[0]; opb = cs_r[2]; odst = 4'd1;    omd = MD_SUB; end
      4'd3:  begin opa = tmp_r;   opb = cs_r[2]; odst = 4'd2;    omd = MD_SET; end
      4'd4:  begin opa = sn_r[0]; opb = sn_r[2]; odst = 4'd2;    omd = MD_ADD; end
      4'd5:  begin opa = sn_r[0]; opb = sn_r[1]; odst = DST_TMP; omd = MD_SET; end
      4'd6:  begin opa = tmp_r;   opb = sn_r[2]; odst = 4'd4;    omd = MD_SET; end
      4'd7:  begin opa = cs_r[0]; opb = cs_r[2]; odst = 4'd4;    omd = MD_ADD; end
      4'd8:  begin opa = tmp_r;   opb = cs_r[2]; odst = 4'd5;    omd = MD_SET; end
      4'd9:  begin opa = cs_r[0]; opb = sn_r[2]; odst = 4'd5;    omd = MD_SUB; end
      4'd10: begin opa = cs_r[0]; opb = cs_r[1]; odst = 4'd0;    omd = MD_SET; end
      4'd11: begin opa = sn_r[0]; opb = cs_r[1]; odst = 4'd3;    omd = MD_SET; end
      4'd12: begin opa = cs_r[1]; opb = sn_r[2]; odst = 4'd7;    omd = MD_SET; end
      4'd13: begin opa = cs_r[1]; opb = cs_r[2]; odst = 4'd8;    omd = MD_SET; end
      default: begin end
    endcase
  end

  // one shared multiplier
  always_comb begin
    case (st_r)
      ST_X2:   begin ma = t_r;  mb = t_r; end
      ST_HMUL: begin ma = x2_r; mb = p_r; end
      ST_SMUL: begin ma = t_r;  mb = p_r; end
      default: begin ma = opa;  mb = opb; end
    endcase
    mw   = pdw_pkg::mul30(ma, mb);
    m    = mw[33:0];
    mabs = m[33] ? 34'(-m) : m;
  end

  // divide by the horner constant through its reciprocal, truncating toward zero
  always_comb begin
    rm    = hrecip(cph_r, h_r);
    rsh   = hshift(cph_r, h_r);
    qprod = dabs_r * rm;
    qmag  = 32'(qprod >> rsh);
    qs    = dneg_r ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    pn    = pdw_pkg::Q30_ONE - qs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_LOAD;
      k_r    <= '0;
      h_r    <= '0;
      cph_r  <= 1'b0;
      op_r   <= '0;
    end else if (start) begin
      st_r <= ST_LOAD;
      k_r  <= '0;
    end else begin
      case (st_r)
        ST_LOAD: begin
          t_r   <= t_fold;
          neg_r <= t_neg;
          st_r  <= ST_X2;
        end
        ST_X2: begin
          x2_r  <= m;
          p_r   <= pdw_pkg::Q30_ONE;
          h_r   <= '0;
          cph_r <= 1'b0;
          st_r  <= ST_HMUL;
        end
        ST_HMUL: begin
          // product magnitude stays below 2^32 since |t| <= pi/2
          dneg_r <= m[33];
          dabs_r <= mabs[31:0];
          st_r   <= ST_DIV;
        end
        ST_DIV: begin
          p_r <= pn;
          if (h_r != H_LAST) begin
            h_r  <= h_r + 3'd1;
            st_r <= ST_HMUL;
          end else if (!cph_r) begin
            st_r <= ST_SMUL;
          end else begin
            cs_r[k_r] <= neg_r ? -pn : pn;
            if (k_r == K_LAST) begin
              op_r <= '0;
              st_r <= ST_MAT;
            end else begin
              k_r  <= k_r + 2'd1;
              st_r <= ST_LOAD;
            end
          end
        end
        ST_SMUL: begin
          sn_r[k_r] <= neg_r ? -m : m;
          p_r       <= pdw_pkg::Q30_ONE;
          h_r       <= '0;
          cph_r     <= 1'b1;
          st_r      <= ST_HMUL;
        end
        ST_MAT: begin
          if (odst == DST_TMP) begin
            tmp_r <= m;
          end else begin
            case (omd)
              MD_ADD:  mat_r[odst] <= mat_r[odst] + m;
              MD_SUB:  mat_r[odst] <= mat_r[odst] - m;
              default: mat_r[odst] <= m;
            endcase
          end
          op_r <= op_r + 4'd1;
          if (op_r == OP_LAST) begin
            mat_r[6] <= -sn_r[1];
            st_r     <= ST_DONE;
          end
        end
        default: begin end
      endcase
    end
  end

  assign stat.busy = (st_r != ST_DONE);
  assign stat.done = (st_r == ST_DONE);
  assign mat       = mat_r;

endmodule

// ----- sv/pixel_depth_to_world_point.sv -----
`timescale 1ns / 1ps
// pixel + depth to world point: back-projects a pixel through a pinhole camera with the
// principal point at the image center, permutes to (depth, x, y), rotates by the
// yaw/pitch/roll matrix and adds the vehicle position; results are q16.16 and saturate.
// throughput is one request per clock while out_ready is high and no matrix rebuild
// runs; 13 register stages, out_valid comes from the last. the stages are input multiply,
// divider setup, 8 divider stages of 4 quotient bits, sign and clip, 9 parallel rotation
// products, sum and output clip. the rotation matrix is rebuilt by a shared-multiplier
// sequencer after reset and after every angle write, with in_ready low until it is done,
// from the write cycle on for an angle write (3 angles, each with ten horner steps of one
// multiply and one reciprocal divide for sine and cosine, then 14 matrix steps). config
// writes are always taken; position and focal length are used live, so write them while
// idle.
module pixel_depth_to_world_point #(
  parameter int IMAGE_WIDTH  = pdw_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = pdw_pkg::DEF_IMAGE_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  // pixel requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_pixel_u,
  input  logic [11:0] in_pixel_v,
  input  logic [23:0] in_depth,
  // world points
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_world_x,
  output logic [31:0] out_world_y,
  output logic [31:0] out_world_z,
  output logic        out_saturated,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NST = pdw_pkg::NDIV + 5;
  localparam int SDV = 2;                   // first divider stage
  localparam int SCL = SDV + pdw_pkg::NDIV; // sign and clip
  localparam int SPR = SCL + 1;             // products
  localparam int SOUT = SPR + 1;            // output register

  localparam logic signed [14:0] WS = 15'(IMAGE_WIDTH);
  localparam logic signed [14:0] HS = 15'(IMAGE_HEIGHT);
  localparam logic signed [39:0] OUT_MAX = 40'sd2147483647;
  localparam logic signed [39:0] OUT_MIN = -40'sd2147483648;

  // configuration registers
  logic [15:0] roll_r, pitch_r, yaw_r, focal_r;
  logic [31:0] posx_r, posy_r, posz_r;

  logic              cfg_we, kick;
  pdw_pkg::rot_stat_t rstat;
  pdw_pkg::q30_t     mat [9];
  logic [15:0]       fe;
  logic [16:0]       dv;

  // pipeline valids and enables
  logic [NST-1:0] v_r, en;

  logic signed [14:0] dx, dy;
  logic signed [39:0] s0_nx_r, s0_ny_r;
  logic [23:0]        s0_dep_r;

  logic [39:0]        ax, ay;
  logic [43:0]        nbx, nby;
  pdw_pkg::div_t      d1_r;
  pdw_pkg::div_t      dv_r [pdw_pkg::NDIV];

  pdw_pkg::div_t      dl;
  logic [32:0]        pmx, pmy;
  pdw_pkg::q30_t      s10_p_r [3];
  logic               s10_sat_r;

  logic signed [37:0] s11_t_r [9];
  logic               s11_sat_r;

  logic signed [39:0] sum [3];
  logic signed [39:0] pos [3];
  logic [31:0]        wo [3];
  logic               osat;
  logic [31:0]        o_r [3];
  logic               o_sat_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign kick      = cfg_we && (cfg_index inside {pdw_pkg::REG_ROLL, pdw_pkg::REG_PITCH,
                                                  pdw_pkg::REG_YAW});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
      posx_r  <= '0;
      posy_r  <= '0;
      posz_r  <= '0;
      focal_r <= 16'd8000;
    end else if (cfg_we) begin
      case (cfg_index)
        pdw_pkg::REG_ROLL:  roll_r  <= cfg_data[15:0];
        pdw_pkg::REG_PITCH: pitch_r <= cfg_data[15:0];
        pdw_pkg::REG_YAW:   yaw_r   <= cfg_data[15:0];
        pdw_pkg::REG_POS_X: posx_r  <= cfg_data;
        pdw_pkg::REG_POS_Y: posy_r  <= cfg_data;
        pdw_pkg::REG_POS_Z: posz_r  <= cfg_data;
        pdw_pkg::REG_FOCAL: focal_r <= cfg_data[15:0];
        default: begin end
      endcase
    end
  end

  // rotation matrix sequencer
  pdw_rot u_rot (
    .clk   (clk),
    .rst_n (rst_n),
    .start (kick),
    .yaw   (yaw_r),
    .pitch (pitch_r),
    .roll  (roll_r),
    .stat  (rstat),
    .mat   (mat)
  );

  // zero focal length acts as 1/16 pixel; divisor is 2f for round half away
  assign fe = (focal_r == 16'd0) ? 16'd1 : focal_r;
  assign dv = {fe, 1'b0};

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0] && !rstat.busy && !kick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid && in_ready;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 0: (2u - w) * depth, (2v - h) * depth
  assign dx = $signed({2'b00, in_pixel_u, 1'b0}) - WS;
  assign dy = $signed({2'b00, in_pixel_v, 1'b0}) - HS;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_nx_r  <= dx * $signed({1'b0, in_depth});
      s0_ny_r  <= dy * $signed({1'b0, in_depth});
      s0_dep_r <= in_depth;
    end
  end

  // stage 1: numerator 2*|num|*8 + f; quotient past 32 bits means camera clip
  always_comb begin
    ax  = s0_nx_r[39] ? 40'(-s0_nx_r) : s0_nx_r;
    ay  = s0_ny_r[39] ? 40'(-s0_ny_r) : s0_ny_r;
    nbx = {ax, 4'd0} + 44'(fe);
    nby = {ay, 4'd0} + 44'(fe);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_r.rx  <= {5'd0, nbx[43:32]};
      d1_r.qx  <= nbx[31:0];
      d1_r.ry  <= {5'd0, nby[43:32]};
      d1_r.qy  <= nby[31:0];
      d1_r.ox  <= ({5'd0, nbx[43:32]} >= dv);
      d1_r.oy  <= ({5'd0, nby[43:32]} >= dv);
      d1_r.sx  <= s0_nx_r[39];
      d1_r.sy  <= s0_ny_r[39];
      d1_r.dep <= s0_dep_r;
    end
  end

  // divider stages
  for (genvar g = 0; g < pdw_pkg::NDIV; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[SDV+g]) begin
        if (g == 0) begin
          dv_r[g] <= pdw_pkg::div_stage(d1_r, dv);
        end else begin
          dv_r[g] <= pdw_pkg::div_stage(dv_r[(g == 0) ? 0 : g-1], dv);
        end
      end
    end
  end

  // sign and camera-plane clip
  always_comb begin
    dl  = dv_r[pdw_pkg::NDIV-1];
    pmx = dl.ox ? pdw_pkg::CAM_LIMIT : {1'b0, dl.qx};
    pmy = dl.oy ? pdw_pkg::CAM_LIMIT : {1'b0, dl.qy};
  end

  always_ff @(posedge clk) begin
    if (en[SCL]) begin
      s10_p_r[0] <= {10'd0, dl.dep};
      s10_p_r[1] <= dl.sx ? -$signed({1'b0, pmx}) : $signed({1'b0, pmx});
      s10_p_r[2] <= dl.sy ? -$signed({1'b0, pmy}) : $signed({1'b0, pmy});
      s10_sat_r  <= dl.ox || dl.oy;
    end
  end

  // rotation products
  always_ff @(posedge clk) begin
    if (en[SPR]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s11_t_r[3*i+j] <= pdw_pkg::mul30(mat[3*i+j], s10_p_r[j]);
        end
      end
      s11_sat_r <= s10_sat_r;
    end
  end

  // sum with position and output clip
  always_comb begin
    pos[0] = {{8{posx_r[31]}}, posx_r};
    pos[1] = {{8{posy_r[31]}}, posy_r};
    pos[2] = {{8{posz_r[31]}}, posz_r};
    osat   = s11_sat_r;
    for (int i = 0; i < 3; i++) begin
      sum[i] = pos[i]
             + {{2{s11_t_r[3*i][37]}},   s11_t_r[3*i]}
             + {{2{s11_t_r[3*i+1][37]}}, s11_t_r[3*i+1]}
             + {{2{s11_t_r[3*i+2][37]}}, s11_t_r[3*i+2]};
      if (sum[i] > OUT_MAX) begin
        wo[i] = OUT_MAX[31:0];
        osat  = 1'b1;
      end else if (sum[i] < OUT_MIN) begin
        wo[i] = OUT_MIN[31:0];
        osat  = 1'b1;
      end else begin
        wo[i] = sum[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[SOUT]) begin
      o_r     <= wo;
      o_sat_r <= osat;
    end
  end

  assign out_valid     = v_r[SOUT];
  assign out_world_x   = o_r[0];
  assign out_world_y   = o_r[1];
  assign out_world_z   = o_r[2];
  assign out_saturated = o_sat_r;

endmodule

// ----- sv/pdw_chk.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pdw_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [11:0] in_pixel_u,
  input logic [11:0] in_pixel_v,
  input logic [23:0] in_depth,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_world_x,
  input logic [31:0] out_world_y,
  input logic [31:0] out_world_z,
  input logic        out_saturated,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_data
);

  // a stalled result holds
  `ASSERT_PROP(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_world_x) && $stable(out_world_y) && $stable(out_world_z) && $stable(out_saturated))

  // nothing comes out right after reset
  `ASSERT_PROP(a_reset_empty, clk, rst_n, $rose(rst_n) |-> !out_valid)

  // an angle write starts a matrix rebuild that blocks requests
  `ASSERT_PROP(a_angle_blocks, clk, rst_n, cfg_valid && cfg_ready && (cfg_index == pdw_pkg::REG_ROLL || cfg_index == pdw_pkg::REG_PITCH || cfg_index == pdw_pkg::REG_YAW) |=> !in_ready)

  // no request taken in the cycle of an angle write
  `ASSERT_NEVER(a_angle_no_req, clk, rst_n, in_ready && cfg_valid && (cfg_index == pdw_pkg::REG_ROLL || cfg_index == pdw_pkg::REG_PITCH || cfg_index == pdw_pkg::REG_YAW))

endmodule

bind pixel_depth_to_world_point pdw_chk u_pdw_chk (.*);
